/* rtl/rcpm_pkg.sv */
// Shared constants, codes and types of the RC pulse command mapper.
package rcpm_pkg;

    localparam int FRAC_BITS = 14;

    localparam int US_W = 15;
    localparam int TPU_W = 2;
    localparam int OPC_W = 2;
    localparam int CMD_W = 17;
    localparam int CMP_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 15;

    localparam int ESC_LIMIT = 8191;
    localparam int ONE = 1 << FRAC_BITS;
    localparam int THR = (ONE + 9) / 10;

    localparam int QUOT_W = FRAC_BITS + 2;
    localparam int DIV_W = US_W;
    localparam int DVD_W = DIV_W + QUOT_W;
    localparam int MAG_W = US_W;
    localparam int LV_W = (QUOT_W + 1 > CMD_W) ? QUOT_W + 1 : CMD_W;
    localparam int CL_W = FRAC_BITS + 2;
    localparam int TK_W = US_W + 1;
    localparam int SQ_W = TK_W + 1;
    localparam int PROD_W = SQ_W + CL_W;
    localparam int T_W = ((PROD_W > SQ_W + FRAC_BITS) ? PROD_W : SQ_W + FRAC_BITS) + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [OPC_W-1:0] OP_RAW = 2'd0;
    localparam logic [OPC_W-1:0] OP_ESC = 2'd1;
    localparam logic [OPC_W-1:0] OP_ACT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PHYS_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHYS_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_US = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_ENABLE = 3'd5;

    typedef enum logic [1:0] {
        KIND_RAW,
        KIND_ESC,
        KIND_ACT
    } kind_t;

    typedef struct packed {
        logic [US_W-1:0]  phys_min_us;
        logic [US_W-1:0]  phys_max_us;
        logic [US_W-1:0]  matrix_min_us;
        logic [US_W-1:0]  matrix_max_us;
        logic [TPU_W-1:0] ticks_per_us;
        logic             output_enable;
    } cfg_t;

    typedef struct packed {
        kind_t                    kind;
        logic signed [CMD_W-1:0]  value;
        logic [DVD_W-1:0]         dividend;
        logic [DIV_W-1:0]         divisor;
        logic                     neg;
    } item_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_status_t;

endpackage

/* rtl/rc_pulse_command_mapper.sv */
// Top level of the RC pulse command mapper: configuration registers and block wiring.
// An input transfer passes the input register, the queue, the divider, the l, m and a stages and the output register.
// Throughput is one transfer per cycle while no stall holds the flow, kept by the 16-stage pipelined divider.
// Commands that give no result leave the pipeline without an output transfer.
// Reset is asynchronous and active low: configuration returns to its defaults and the
// input register, queue and pipeline empty at once.
module rc_pulse_command_mapper (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [rcpm_pkg::OPC_W-1:0]              opcode,
    input  logic signed [rcpm_pkg::CMD_W-1:0]       command_value,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [rcpm_pkg::CMP_W-1:0]              compare_value,
    input  logic                                    cfg_we,
    input  logic [rcpm_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [rcpm_pkg::CFG_DATA_W-1:0]         cfg_data
);

    logic [rcpm_pkg::US_W-1:0]   phys_min_reg;
    logic [rcpm_pkg::US_W-1:0]   phys_max_reg;
    logic [rcpm_pkg::US_W-1:0]   matrix_min_reg;
    logic [rcpm_pkg::US_W-1:0]   matrix_max_reg;
    logic [rcpm_pkg::TPU_W-1:0]  ticks_reg;
    logic                        enable_reg;

    rcpm_pkg::cfg_t              cfg;
    rcpm_pkg::q_status_t         q_status;
    rcpm_pkg::item_t             q_wr_item;
    rcpm_pkg::item_t             q_rd_item;
    logic                        q_push;
    logic                        q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phys_min_reg <= rcpm_pkg::US_W'(1000);
            phys_max_reg <= rcpm_pkg::US_W'(2000);
            matrix_min_reg <= rcpm_pkg::US_W'(1000);
            matrix_max_reg <= rcpm_pkg::US_W'(2000);
            ticks_reg <= rcpm_pkg::TPU_W'(1);
            enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rcpm_pkg::REG_PHYS_MIN:      phys_min_reg <= cfg_data[rcpm_pkg::US_W-1:0];
                rcpm_pkg::REG_PHYS_MAX:      phys_max_reg <= cfg_data[rcpm_pkg::US_W-1:0];
                rcpm_pkg::REG_MATRIX_MIN:    matrix_min_reg <= cfg_data[rcpm_pkg::US_W-1:0];
                rcpm_pkg::REG_MATRIX_MAX:    matrix_max_reg <= cfg_data[rcpm_pkg::US_W-1:0];
                rcpm_pkg::REG_TICKS_PER_US:  ticks_reg <= cfg_data[rcpm_pkg::TPU_W-1:0];
                rcpm_pkg::REG_OUTPUT_ENABLE: enable_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.phys_min_us = phys_min_reg;
        cfg.phys_max_us = phys_max_reg;
        cfg.matrix_min_us = matrix_min_reg;
        cfg.matrix_max_us = matrix_max_reg;
        cfg.ticks_per_us = ticks_reg;
        cfg.output_enable = enable_reg;
    end

    rcpm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .command_value (command_value),
        .cfg           (cfg),
        .q_status      (q_status),
        .push          (q_push),
        .item          (q_wr_item)
    );

    rcpm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_item (q_wr_item),
        .pop     (q_pop),
        .rd_item (q_rd_item),
        .status  (q_status)
    );

    rcpm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (!q_status.empty),
        .head          (q_rd_item),
        .pop           (q_pop),
        .cfg           (cfg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .compare_value (compare_value)
    );

    // The pipeline must not take an item from the queue while the output transfer is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !q_pop)
        else $error("queue popped while the output is stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.empty |-> !q_pop)
        else $error("queue popped while empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_pop) |=> (q_status.count == $past(q_status.count) + 1))
        else $error("queue fill count did not follow a push");

endmodule

/* rtl/rcpm_front.sv */
// Front end: input register, opcode classification and esc pulse preparation.
module rcpm_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [rcpm_pkg::OPC_W-1:0]          opcode,
    input  logic signed [rcpm_pkg::CMD_W-1:0]   command_value,
    input  rcpm_pkg::cfg_t                      cfg,
    input  rcpm_pkg::q_status_t                 q_status,
    output logic                                push,
    output rcpm_pkg::item_t                     item
);

    localparam logic signed [rcpm_pkg::CMD_W-1:0] LIM_P = rcpm_pkg::CMD_W'(rcpm_pkg::ESC_LIMIT);
    localparam logic signed [rcpm_pkg::CMD_W-1:0] LIM_N = -LIM_P;

    logic                               fr_valid_reg;
    logic [rcpm_pkg::OPC_W-1:0]         fr_opcode_reg;
    logic signed [rcpm_pkg::CMD_W-1:0]  fr_value_reg;
    logic                               advance;

    logic signed [rcpm_pkg::CMD_W-1:0]  pmin_s;
    logic signed [rcpm_pkg::CMD_W-1:0]  pmax_s;
    logic signed [rcpm_pkg::CMD_W-1:0]  v_lim;
    logic signed [rcpm_pkg::CMD_W-1:0]  v_hi;
    logic signed [rcpm_pkg::CMD_W-1:0]  v_clamp;
    logic signed [rcpm_pkg::US_W:0]     diff;
    logic [rcpm_pkg::US_W-2:0]          half;
    logic signed [rcpm_pkg::CMD_W-1:0]  mid_s;
    logic signed [rcpm_pkg::CMD_W-1:0]  delta;
    logic signed [rcpm_pkg::CMD_W-1:0]  delta_abs;
    logic [rcpm_pkg::MAG_W-1:0]         mag;
    logic                               keep;

    assign advance = !fr_valid_reg || !q_status.full;
    assign in_stall = fr_valid_reg && q_status.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            fr_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            fr_opcode_reg <= opcode;
            fr_value_reg <= command_value;
        end
    end

    always_comb
    begin
        pmin_s = $signed(rcpm_pkg::CMD_W'(cfg.phys_min_us));
        pmax_s = $signed(rcpm_pkg::CMD_W'(cfg.phys_max_us));
        if (fr_value_reg > LIM_P)
        begin
            v_lim = LIM_P;
        end
        else if (fr_value_reg < LIM_N)
        begin
            v_lim = LIM_N;
        end
        else
        begin
            v_lim = fr_value_reg;
        end
        v_hi = (v_lim > pmax_s) ? pmax_s : v_lim;
        v_clamp = (v_hi < pmin_s) ? pmin_s : v_hi;
        diff = $signed({1'b0, cfg.phys_max_us}) - $signed({1'b0, cfg.phys_min_us});
        half = diff[rcpm_pkg::US_W-1:1];
        mid_s = pmin_s + $signed(rcpm_pkg::CMD_W'(half));
        delta = v_clamp - mid_s;
        delta_abs = delta[rcpm_pkg::CMD_W-1] ? -delta : delta;
        mag = delta_abs[rcpm_pkg::MAG_W-1:0];
    end

    always_comb
    begin
        item.value = fr_value_reg;
        item.dividend = '0;
        item.divisor = '0;
        item.neg = 1'b0;
        unique case (fr_opcode_reg)
            rcpm_pkg::OP_RAW:
            begin
                keep = 1'b1;
                item.kind = rcpm_pkg::KIND_RAW;
            end
            rcpm_pkg::OP_ESC:
            begin
                keep = (diff > 1);
                item.kind = rcpm_pkg::KIND_ESC;
                item.dividend = (rcpm_pkg::DVD_W'(mag) << (rcpm_pkg::FRAC_BITS + 1))
                              + rcpm_pkg::DVD_W'(half);
                item.divisor = {half, 1'b0};
                item.neg = delta[rcpm_pkg::CMD_W-1];
            end
            rcpm_pkg::OP_ACT:
            begin
                keep = 1'b1;
                item.kind = rcpm_pkg::KIND_ACT;
            end
            default:
            begin
                keep = 1'b0;
                item.kind = rcpm_pkg::KIND_RAW;
            end
        endcase
    end

    assign push = fr_valid_reg && !q_status.full && keep;

endmodule

/* rtl/rcpm_queue.sv */
// Short queue that decouples the front end from the mapping pipeline.
module rcpm_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rcpm_pkg::item_t      wr_item,
    input  logic                 pop,
    output rcpm_pkg::item_t      rd_item,
    output rcpm_pkg::q_status_t  status
);

    rcpm_pkg::item_t                 entry_reg [rcpm_pkg::QUEUE_DEPTH];
    logic [rcpm_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [rcpm_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [rcpm_pkg::QCNT_W-1:0]     count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + rcpm_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + rcpm_pkg::QPTR_W'(1);
            end
            priority if (push && !pop)
            begin
                count_reg <= count_reg + rcpm_pkg::QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - rcpm_pkg::QCNT_W'(1);
            end
            else
            begin
                count_reg <= count_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

    assign rd_item = entry_reg[rd_ptr_reg];
    assign status.full = (count_reg == rcpm_pkg::QCNT_W'(rcpm_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;

endmodule

/* rtl/rcpm_back.sv */
// Back end: pipelined divider, logical value mapping and output register.
module rcpm_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  rcpm_pkg::item_t               head,
    output logic                          pop,
    input  rcpm_pkg::cfg_t                cfg,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rcpm_pkg::CMP_W-1:0]    compare_value
);

    typedef struct packed {
        rcpm_pkg::kind_t                     kind;
        logic signed [rcpm_pkg::CMD_W-1:0]   value;
        logic [rcpm_pkg::DVD_W-1:0]          rem;
        logic [rcpm_pkg::DIV_W-1:0]          divisor;
        logic [rcpm_pkg::QUOT_W-1:0]         quot;
        logic                                neg;
    } div_stage_t;

    localparam logic signed [rcpm_pkg::CL_W-1:0] ONE_S = rcpm_pkg::CL_W'(rcpm_pkg::ONE);

    function automatic div_stage_t div_step(div_stage_t s, int shift);
        logic [rcpm_pkg::DVD_W-1:0] trial;
        logic                       ge;
        div_stage_t                 r;
        trial = rcpm_pkg::DVD_W'(s.divisor) << shift;
        ge = (s.rem >= trial);
        r = s;
        if (ge)
        begin
            r.rem = s.rem - trial;
        end
        r.quot = {s.quot[rcpm_pkg::QUOT_W-2:0], ge};
        return r;
    endfunction

    logic                                advance;
    div_stage_t                          div_in;
    div_stage_t                          div_reg [rcpm_pkg::QUOT_W];
    logic [rcpm_pkg::QUOT_W-1:0]         div_valid_reg;
    div_stage_t                          last;

    logic signed [rcpm_pkg::SQ_W-1:0]    q_reg;
    logic signed [rcpm_pkg::SQ_W-1:0]    mid_reg;
    logic [rcpm_pkg::TK_W-1:0]           pmin_t_reg;
    logic [rcpm_pkg::TK_W-1:0]           pmax_t_reg;
    logic [rcpm_pkg::TK_W-1:0]           mn;
    logic [rcpm_pkg::TK_W-1:0]           mx;
    logic signed [rcpm_pkg::SQ_W-1:0]    diffm;
    logic signed [rcpm_pkg::SQ_W-1:0]    diffm_adj;
    logic signed [rcpm_pkg::SQ_W-1:0]    q_c;

    logic signed [rcpm_pkg::LV_W-1:0]    lv_full;
    logic signed [rcpm_pkg::CL_W-1:0]    lv_clamp;
    logic                                drop;

    logic                                l_valid_reg;
    logic                                l_raw_reg;
    logic [rcpm_pkg::CMP_W-1:0]          l_rawval_reg;
    logic signed [rcpm_pkg::CL_W-1:0]    l_lv_reg;

    logic                                m_valid_reg;
    logic                                m_raw_reg;
    logic [rcpm_pkg::CMP_W-1:0]          m_rawval_reg;
    logic signed [rcpm_pkg::PROD_W-1:0]  m_prod_reg;

    logic                                a_valid_reg;
    logic                                a_raw_reg;
    logic [rcpm_pkg::CMP_W-1:0]          a_rawval_reg;
    logic signed [rcpm_pkg::T_W-1:0]     a_t_reg;

    logic signed [rcpm_pkg::T_W-1:0]     t_shift;
    logic [rcpm_pkg::TK_W-1:0]           val_scaled;
    logic [rcpm_pkg::TK_W-1:0]           val_hi;
    logic [rcpm_pkg::TK_W-1:0]           val_fin;
    logic [rcpm_pkg::CMP_W-1:0]          out_cmp_next;

    logic                                out_valid_reg;
    logic [rcpm_pkg::CMP_W-1:0]          out_cmp_reg;

    assign advance = !out_valid_reg || !out_stall;
    assign pop = advance && head_valid;

    always_comb
    begin
        div_in.kind = head.kind;
        div_in.value = head.value;
        div_in.rem = head.dividend;
        div_in.divisor = head.divisor;
        div_in.quot = '0;
        div_in.neg = head.neg;
    end

    always_comb
    begin
        if (cfg.ticks_per_us[1])
        begin
            mn = {cfg.matrix_min_us, 1'b0};
            mx = {cfg.matrix_max_us, 1'b0};
        end
        else
        begin
            mn = {1'b0, cfg.matrix_min_us};
            mx = {1'b0, cfg.matrix_max_us};
        end
        diffm = $signed({1'b0, mx}) - $signed({1'b0, mn});
        diffm_adj = diffm + rcpm_pkg::SQ_W'(diffm[rcpm_pkg::SQ_W-1]);
        q_c = diffm_adj >>> 1;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_c;
        mid_reg <= $signed({1'b0, mn}) + q_c;
        if (cfg.ticks_per_us[1])
        begin
            pmin_t_reg <= {cfg.phys_min_us, 1'b0};
            pmax_t_reg <= {cfg.phys_max_us, 1'b0};
        end
        else
        begin
            pmin_t_reg <= {1'b0, cfg.phys_min_us};
            pmax_t_reg <= {1'b0, cfg.phys_max_us};
        end
    end

    assign last = div_reg[rcpm_pkg::QUOT_W-1];

    always_comb
    begin
        unique case (last.kind)
            rcpm_pkg::KIND_ESC:
            begin
                lv_full = $signed(rcpm_pkg::LV_W'(last.quot));
                if (last.neg)
                begin
                    lv_full = -lv_full;
                end
            end
            rcpm_pkg::KIND_ACT:
            begin
                lv_full = rcpm_pkg::LV_W'($signed(last.value));
            end
            default:
            begin
                lv_full = '0;
            end
        endcase
        drop = (last.kind != rcpm_pkg::KIND_RAW)
            && (lv_full > -rcpm_pkg::THR) && (lv_full < rcpm_pkg::THR);
        if (lv_full > rcpm_pkg::ONE)
        begin
            lv_clamp = ONE_S;
        end
        else if (lv_full < -rcpm_pkg::ONE)
        begin
            lv_clamp = -ONE_S;
        end
        else
        begin
            lv_clamp = lv_full[rcpm_pkg::CL_W-1:0];
        end
    end

    always_comb
    begin
        t_shift = a_t_reg >>> rcpm_pkg::FRAC_BITS;
        val_scaled = a_t_reg[rcpm_pkg::T_W-1] ? '0 : t_shift[rcpm_pkg::TK_W-1:0];
        val_hi = (val_scaled > pmax_t_reg) ? pmax_t_reg : val_scaled;
        val_fin = (val_hi < pmin_t_reg) ? pmin_t_reg : val_hi;
        if (!cfg.output_enable)
        begin
            out_cmp_next = '0;
        end
        else if (a_raw_reg)
        begin
            out_cmp_next = a_rawval_reg;
        end
        else
        begin
            out_cmp_next = rcpm_pkg::CMP_W'(val_fin);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_valid_reg <= '0;
            l_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            div_valid_reg <= {div_valid_reg[rcpm_pkg::QUOT_W-2:0], head_valid};
            l_valid_reg <= div_valid_reg[rcpm_pkg::QUOT_W-1] && !drop;
            m_valid_reg <= l_valid_reg;
            a_valid_reg <= m_valid_reg;
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            div_reg[0] <= div_step(div_in, rcpm_pkg::QUOT_W - 1);
            for (int k = 1; k < rcpm_pkg::QUOT_W; k++)
            begin
                div_reg[k] <= div_step(div_reg[k-1], rcpm_pkg::QUOT_W - 1 - k);
            end
            l_raw_reg <= (last.kind == rcpm_pkg::KIND_RAW);
            l_rawval_reg <= last.value[rcpm_pkg::CMP_W-1:0];
            l_lv_reg <= lv_clamp;
            m_raw_reg <= l_raw_reg;
            m_rawval_reg <= l_rawval_reg;
            m_prod_reg <= q_reg * l_lv_reg;
            a_raw_reg <= m_raw_reg;
            a_rawval_reg <= m_rawval_reg;
            a_t_reg <= rcpm_pkg::T_W'(m_prod_reg)
                     + (rcpm_pkg::T_W'(mid_reg) <<< rcpm_pkg::FRAC_BITS);
            out_cmp_reg <= out_cmp_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign compare_value = out_cmp_reg;

endmodule

/* dv/compare_value_checker.sv */
`timescale 1ns / 1ps
// Checker for the RC pulse command mapper: predicts each compare value and compares it.
module compare_value_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [rcpm_pkg::OPC_W-1:0]          opcode,
    input  logic signed [rcpm_pkg::CMD_W-1:0]   command_value,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [rcpm_pkg::CMP_W-1:0]          compare_value,
    input  logic                                cfg_we,
    input  logic [rcpm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rcpm_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  failures,
    output int                                  pending,
    output int                                  accepted_count,
    output int                                  checked_count
);
    import rcpm_pkg::*;

    cfg_t             settings;
    logic [CMP_W-1:0] expected_compare[$];
    int               errors;
    int               accepted;
    int               checked;

    function automatic logic scale_logical(input longint level, output logic [CMP_W-1:0] ticks);
        longint tpu;
        longint lo;
        longint hi;
        longint phys_lo;
        longint phys_hi;
        longint span;
        longint centre;
        longint acc;
        longint val;
        ticks = '0;
        if (level > -THR && level < THR)
        begin
            return 1'b0;
        end
        if (level > ONE)
        begin
            level = ONE;
        end
        if (level < -ONE)
        begin
            level = -ONE;
        end
        tpu = longint'(settings.ticks_per_us);
        if (tpu == 0)
        begin
            tpu = 1;
        end
        if (tpu > 2)
        begin
            tpu = 2;
        end
        lo = longint'(settings.matrix_min_us) * tpu;
        hi = longint'(settings.matrix_max_us) * tpu;
        phys_lo = longint'(settings.phys_min_us) * tpu;
        phys_hi = longint'(settings.phys_max_us) * tpu;
        span = (hi - lo) / 2;
        centre = lo + span;
        acc = centre * ONE + span * level;
        val = (acc >= 0) ? acc / ONE : 0;
        if (val > phys_hi)
        begin
            val = phys_hi;
        end
        if (val < phys_lo)
        begin
            val = phys_lo;
        end
        if (val < 0)
        begin
            val = 0;
        end
        if (val > 65535)
        begin
            val = 65535;
        end
        ticks = settings.output_enable ? val[CMP_W-1:0] : '0;
        return 1'b1;
    endfunction

    function automatic logic predict_compare(input logic [OPC_W-1:0] op,
                                             input logic signed [CMD_W-1:0] cmd,
                                             output logic [CMP_W-1:0] ticks);
        longint pulse;
        longint phys_lo;
        longint phys_hi;
        longint half;
        longint centre;
        longint num;
        longint mag;
        ticks = '0;
        case (op)
            OP_RAW:
            begin
                ticks = settings.output_enable ? cmd[CMP_W-1:0] : '0;
                return 1'b1;
            end
            OP_ESC:
            begin
                pulse = longint'(cmd);
                phys_lo = longint'(settings.phys_min_us);
                phys_hi = longint'(settings.phys_max_us);
                if (pulse > ESC_LIMIT)
                begin
                    pulse = ESC_LIMIT;
                end
                if (pulse < -ESC_LIMIT)
                begin
                    pulse = -ESC_LIMIT;
                end
                if (pulse > phys_hi)
                begin
                    pulse = phys_hi;
                end
                if (pulse < phys_lo)
                begin
                    pulse = phys_lo;
                end
                if (phys_hi - phys_lo < 2)
                begin
                    return 1'b0;
                end
                half = (phys_hi - phys_lo) / 2;
                centre = phys_lo + half;
                num = (pulse - centre) * ONE;
                mag = (num < 0) ? -num : num;
                mag = (2 * mag + half) / (2 * half);
                return scale_logical((num < 0) ? -mag : mag, ticks);
            end
            OP_ACT:
            begin
                return scale_logical(longint'(cmd), ticks);
            end
            default:
            begin
                return 1'b0;
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        logic [CMP_W-1:0] want;
        if (!rst_n)
        begin
            settings.phys_min_us = 15'd1000;
            settings.phys_max_us = 15'd2000;
            settings.matrix_min_us = 15'd1000;
            settings.matrix_max_us = 15'd2000;
            settings.ticks_per_us = 2'd1;
            settings.output_enable = 1'b0;
            expected_compare.delete();
            errors = 0;
            accepted = 0;
            checked = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PHYS_MIN:      settings.phys_min_us = cfg_data;
                    REG_PHYS_MAX:      settings.phys_max_us = cfg_data;
                    REG_MATRIX_MIN:    settings.matrix_min_us = cfg_data;
                    REG_MATRIX_MAX:    settings.matrix_max_us = cfg_data;
                    REG_TICKS_PER_US:  settings.ticks_per_us = cfg_data[TPU_W-1:0];
                    REG_OUTPUT_ENABLE: settings.output_enable = cfg_data[0];
                    default:           ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_compare.size() == 0)
                begin
                    errors++;
                    $error("compare_value: expected no transfer, actual %0d", compare_value);
                end
                else
                begin
                    want = expected_compare.pop_front();
                    checked++;
                    if (compare_value !== want)
                    begin
                        errors++;
                        $error("compare_value: expected %0d, actual %0d", want, compare_value);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                accepted++;
                if (predict_compare(opcode, command_value, want))
                begin
                    expected_compare.push_back(want);
                end
            end
        end
        failures <= errors;
        pending <= expected_compare.size();
        accepted_count <= accepted;
        checked_count <= checked;
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Top of the RC pulse command mapper testbench: clock, reset, stimulus and verdict.
module tb;
    import rcpm_pkg::*;

    localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 32;
    localparam int PHASE_ITEMS = 95;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [OPC_W-1:0]        opcode;
    logic signed [CMD_W-1:0] command_value;
    logic                    out_valid;
    logic                    out_stall;
    logic [CMP_W-1:0]        compare_value;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    int failures;
    int pending_results;
    int accepted_commands;
    int checked_results;
    int cycles = 0;
    int settings_applied;
    int steady_left;
    int esc_lo;
    int esc_hi;

    rc_pulse_command_mapper dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .command_value (command_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .compare_value (compare_value),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    compare_value_checker value_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .command_value  (command_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .compare_value  (compare_value),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .failures       (failures),
        .pending        (pending_results),
        .accepted_count (accepted_commands),
        .checked_count  (checked_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 25);
    endfunction

    function automatic logic [OPC_W-1:0] pick_opcode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            return OP_RAW;
        end
        if (r < 55)
        begin
            return OP_ESC;
        end
        if (r < 96)
        begin
            return OP_ACT;
        end
        return OP_UNUSED;
    endfunction

    function automatic int pick_command(input logic [OPC_W-1:0] op);
        int r;
        int magnitude;
        r = $urandom_range(0, 9);
        if (r == 9 || op == OP_RAW || op == OP_UNUSED)
        begin
            return int'($urandom);
        end
        if (op == OP_ESC)
        begin
            if (r < 7)
            begin
                return esc_lo - 200 + int'($urandom_range(0, esc_hi - esc_lo + 400));
            end
            return int'($urandom_range(0, 20000)) - 10000;
        end
        if (r < 6)
        begin
            return int'($urandom_range(0, 36000)) - 18000;
        end
        magnitude = (r == 6) ? THR - 1 + int'($urandom_range(0, 1))
                             : ONE - 1 + int'($urandom_range(0, 2));
        return ($urandom_range(0, 1) == 1) ? -magnitude : magnitude;
    endfunction

    task automatic send_command(input logic [OPC_W-1:0] op, input int value);
        int gap;
        gap = 0;
        if (steady_left > 0)
        begin
            steady_left--;
        end
        else if ($urandom_range(0, 99) < 3)
        begin
            steady_left = $urandom_range(20, 60);
        end
        else
        begin
            gap = idle_length();
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        command_value <= value[CMD_W-1:0];
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input int data);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data[CFG_DATA_W-1:0];
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input int pmin, input int pmax, input int mmin,
                                  input int mmax, input int tpu, input int enable);
        drain();
        write_register(REG_PHYS_MIN, pmin);
        write_register(REG_PHYS_MAX, pmax);
        write_register(REG_MATRIX_MIN, mmin);
        write_register(REG_MATRIX_MAX, mmax);
        write_register(REG_TICKS_PER_US, tpu);
        write_register(REG_OUTPUT_ENABLE, enable);
        cfg_we <= 1'b0;
        esc_lo = (pmin < pmax) ? pmin : pmax;
        esc_hi = (pmin < pmax) ? pmax : pmin;
        settings_applied++;
    endtask

    task automatic run_phase(input int count);
        logic [OPC_W-1:0] op;
        int sent;
        sent = 0;
        while (sent < count)
        begin
            op = pick_opcode();
            send_command(op, pick_command(op));
            if (op != OP_UNUSED)
            begin
                sent++;
            end
        end
    endtask

    initial
    begin : receiver
        int run;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
            out_stall <= 1'b0;
            repeat (run) @(posedge clk);
            out_stall <= 1'b1;
            repeat (1 + idle_length()) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int pmin;
        int pmax;
        int swap;
        int k;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        opcode <= OP_RAW;
        command_value <= '0;
        cfg_we <= 1'b0;
        cfg_index <= REG_PHYS_MIN;
        cfg_data <= '0;
        settings_applied = 0;
        steady_left = 0;
        esc_lo = 1000;
        esc_hi = 2000;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_settings(1000, 2000, 1000, 2000, 1, 1);
        send_command(OP_RAW, 0);
        send_command(OP_RAW, 65535);
        send_command(OP_RAW, -65536);
        send_command(OP_RAW, -1);
        send_command(OP_ESC, -65536);
        send_command(OP_ESC, -8192);
        send_command(OP_ESC, 8192);
        send_command(OP_ESC, 65535);
        send_command(OP_ESC, 1000);
        send_command(OP_ESC, 2000);
        send_command(OP_ESC, 1500);
        send_command(OP_ESC, 1550);
        send_command(OP_ESC, 1551);
        send_command(OP_ACT, -65536);
        send_command(OP_ACT, 65535);
        send_command(OP_ACT, ONE);
        send_command(OP_ACT, -ONE);
        send_command(OP_ACT, THR - 1);
        send_command(OP_ACT, THR);
        send_command(OP_ACT, -THR + 1);
        send_command(OP_ACT, -THR);
        send_command(OP_ACT, 0);
        send_command(OP_UNUSED, 1500);
        send_command(OP_UNUSED, -1);
        run_phase(PHASE_ITEMS);

        apply_settings(0, 32000, 0, 32000, 2, 1);
        run_phase(PHASE_ITEMS);
        apply_settings(0, 32767, 32767, 0, 3, 1);
        run_phase(PHASE_ITEMS);
        apply_settings(1500, 1501, 1000, 2000, 0, 1);
        run_phase(PHASE_ITEMS);
        apply_settings(2000, 1000, 900, 2100, 1, 1);
        run_phase(PHASE_ITEMS);
        apply_settings(1000, 2000, 1000, 2000, 1, 0);
        run_phase(PHASE_ITEMS);
        apply_settings(32000, 32000, 0, 0, 2, 1);
        run_phase(PHASE_ITEMS);

        for (k = 0; k < 5; k++)
        begin
            if (k % 2 == 0)
            begin
                pmin = $urandom_range(0, 3000);
                pmax = pmin + $urandom_range(0, 3000);
            end
            else
            begin
                pmin = $urandom_range(0, 32767);
                pmax = $urandom_range(0, 32767);
                if (pmin > pmax && $urandom_range(0, 3) != 0)
                begin
                    swap = pmin;
                    pmin = pmax;
                    pmax = swap;
                end
            end
            apply_settings(pmin, pmax, $urandom_range(0, 32767), $urandom_range(0, 32767),
                           $urandom_range(0, 3), ($urandom_range(0, 4) != 0) ? 1 : 0);
            run_phase(PHASE_ITEMS);
        end

        drain();
        $display("Covered %0d commands under %0d register settings; %0d compare values checked.",
                 accepted_commands, settings_applied, checked_results);
        if (failures == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/rcpm_pkg.sv
rtl/rcpm_front.sv
rtl/rcpm_queue.sv
rtl/rcpm_back.sv
rtl/rc_pulse_command_mapper.sv
dv/compare_value_checker.sv
dv/tb.sv
